// ----- sv/ray_triangle_intersect_defines.svh -----
// Assertion macros shared by the ray/triangle intersection RTL.
// No dependencies; included by modules that carry assertions.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Implication checked every cycle outside reset.
`define RTI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked while reset is applied.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rti_pkg.sv -----
// Types and constants for the ray/triangle intersection pipeline.
// No dependencies.
package rti_pkg;

    localparam int W_COORD   = 32;   // Q16.16 coordinate
    localparam int W_DET     = 99;   // |det| magnitude bits
    localparam int W_N       = 128;  // exact numerator / det datapath
    localparam int W_MAG     = 116;  // |nt| << 16
    localparam int W_DIV     = 150;  // divider trial width
    localparam int N_QBITS   = 49;   // quotient bits resolved by the divider
    localparam int W_DIST    = 48;
    localparam int W_CFG_IDX = 4;
    localparam int W_CFG_DAT = 64;
    localparam int W_EPS     = 16;

    localparam logic [W_DIST-1:0]  DIST_MAX  = {1'b0, {(W_DIST-1){1'b1}}};
    localparam logic [N_QBITS-1:0] Q_POS_MAX = N_QBITS'(DIST_MAX);
    localparam logic [N_QBITS-1:0] Q_NEG_MAX = N_QBITS'(1) << (W_DIST-1);

    typedef enum logic [2:0] {
        REG_EDGE_A_X   = 3'd0,
        REG_EDGE_A_Y   = 3'd1,
        REG_EDGE_A_Z   = 3'd2,
        REG_EDGE_B_X   = 3'd3,
        REG_EDGE_B_Y   = 3'd4,
        REG_EDGE_B_Z   = 3'd5,
        REG_VERTEX_AXY = 3'd6,
        REG_VERTEX_AZ  = 3'd7
    } t_reg_idx;

    // Per-stage control that travels with a transaction.
    typedef struct packed {
        logic valid;
        logic miss;
        logic negt;
        logic ovf;
    } t_ctl;

endpackage

// ----- sv/ray_triangle_intersect.sv -----
// Top level of the Moller-Trumbore ray/triangle intersection pipeline.
// Depends on rti_pkg, rti_geom, rti_bary, rti_div and the defines header.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  ray in   | i_in_valid / o_in_ready     | i_origin_x/y/z, i_dir_x/y/z (Q16.16)
//  result   | o_out_valid / i_out_ready   | o_hit, o_distance (Q32.16)
//  config   | i_cfg_we (no back-pressure) | i_cfg_idx, i_cfg_data
//
// One ray enters per cycle unless a stalled result holds the pipe. Stages:
// 7 geometry, 4 test, one overflow check, 49 divider (one quotient bit
// each) and the output register. The divider chain sets the depth.
// Reset is synchronous and active low: it clears the valid bits and the
// triangle registers. A stalled result freezes the whole pipeline, so no
// transaction is dropped or repeated; bubbles fill as the output drains.
`include "ray_triangle_intersect_defines.svh"

module ray_triangle_intersect #(
    parameter int EPSILON_LSB = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [rti_pkg::W_COORD-1:0]   i_origin_x,
    input  logic signed [rti_pkg::W_COORD-1:0]   i_origin_y,
    input  logic signed [rti_pkg::W_COORD-1:0]   i_origin_z,
    input  logic signed [rti_pkg::W_COORD-1:0]   i_dir_x,
    input  logic signed [rti_pkg::W_COORD-1:0]   i_dir_y,
    input  logic signed [rti_pkg::W_COORD-1:0]   i_dir_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_hit,
    output logic signed [rti_pkg::W_DIST-1:0]    o_distance,
    input  logic                                 i_cfg_we,
    input  logic        [rti_pkg::W_CFG_IDX-1:0] i_cfg_idx,
    input  logic        [rti_pkg::W_CFG_DAT-1:0] i_cfg_data
);
    import rti_pkg::*;

    // triangle registers
    logic signed [W_COORD-1:0] r_ea [3];
    logic signed [W_COORD-1:0] r_eb [3];
    logic signed [W_COORD-1:0] r_va [3];

    logic signed [W_COORD-1:0] org [3];
    logic signed [W_COORD-1:0] dir [3];

    logic                  en;
    logic                  geo_valid;
    logic [W_DET-1:0]      geo_det;
    logic signed [W_N-1:0] geo_nu, geo_nv, geo_nt;
    t_ctl                  tst_ctl;
    logic [W_DET-1:0]      tst_det;
    logic [W_MAG-1:0]      tst_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ea <= '{default: '0};
            r_eb <= '{default: '0};
            r_va <= '{default: '0};
        end else if (i_cfg_we && !i_cfg_idx[W_CFG_IDX-1]) begin
            unique case (t_reg_idx'(i_cfg_idx[2:0]))
                REG_EDGE_A_X:   r_ea[0] <= i_cfg_data[31:0];
                REG_EDGE_A_Y:   r_ea[1] <= i_cfg_data[31:0];
                REG_EDGE_A_Z:   r_ea[2] <= i_cfg_data[31:0];
                REG_EDGE_B_X:   r_eb[0] <= i_cfg_data[31:0];
                REG_EDGE_B_Y:   r_eb[1] <= i_cfg_data[31:0];
                REG_EDGE_B_Z:   r_eb[2] <= i_cfg_data[31:0];
                REG_VERTEX_AXY: begin
                    r_va[0] <= i_cfg_data[63:32];
                    r_va[1] <= i_cfg_data[31:0];
                end
                REG_VERTEX_AZ:  r_va[2] <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances unless a finished result is held at the output
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};

    rti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_org   (org),
        .i_dir   (dir),
        .i_ea    (r_ea),
        .i_eb    (r_eb),
        .i_va    (r_va),
        .o_valid (geo_valid),
        .o_det   (geo_det),
        .o_nu    (geo_nu),
        .o_nv    (geo_nv),
        .o_nt    (geo_nt)
    );

    rti_bary #(
        .EPSILON_LSB (EPSILON_LSB)
    ) u_bary (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geo_valid),
        .i_det   (geo_det),
        .i_nu    (geo_nu),
        .i_nv    (geo_nv),
        .i_nt    (geo_nt),
        .o_ctl   (tst_ctl),
        .o_det   (tst_det),
        .o_mag   (tst_mag)
    );

    rti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (tst_ctl),
        .i_det      (tst_det),
        .i_mag      (tst_mag),
        .o_valid    (o_out_valid),
        .o_hit      (o_hit),
        .o_distance (o_distance)
    );

    `RTI_ASSERT_IMPL(a_miss_zero, o_out_valid && !o_hit, o_distance == '0, "miss with distance")
    `RTI_ASSERT_IMPL(a_stall_blocks, o_out_valid && !i_out_ready, !o_in_ready, "ray taken in stall")
    `RTI_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

// ----- sv/rti_geom.sv -----
// Geometry front end: S = O - A, P = D x EB, Q = S x EA and the four exact dots.
// Depends on rti_pkg.
module rti_geom (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [rti_pkg::W_COORD-1:0]  i_org [3],
    input  logic signed [rti_pkg::W_COORD-1:0]  i_dir [3],
    input  logic signed [rti_pkg::W_COORD-1:0]  i_ea  [3],
    input  logic signed [rti_pkg::W_COORD-1:0]  i_eb  [3],
    input  logic signed [rti_pkg::W_COORD-1:0]  i_va  [3],
    output logic                                o_valid,
    output logic        [rti_pkg::W_DET-1:0]    o_det,
    output logic signed [rti_pkg::W_N-1:0]      o_nu,
    output logic signed [rti_pkg::W_N-1:0]      o_nv,
    output logic signed [rti_pkg::W_N-1:0]      o_nt
);
    import rti_pkg::*;

    localparam int N_STG = 7;

    logic [N_STG-1:0] r_v;

    logic signed [32:0]  r1_s [3], r2_s [3], r3_s [3];
    logic signed [31:0]  r1_dir [3], r2_dir [3], r3_dir [3];
    logic signed [63:0]  r2_pp [6];
    logic signed [64:0]  r2_qp [6];
    logic signed [64:0]  r3_p [3];
    logic signed [65:0]  r3_q [3];
    logic signed [32:0]  opa [4][3];
    logic signed [65:0]  opb [4][3];
    logic signed [67:0]  n_lo [4][3], n_hi [4][3];
    logic signed [67:0]  r4_lo [4][3], r4_hi [4][3];
    logic signed [69:0]  r5_lo [4], r5_hi [4];
    logic signed [W_N-1:0] r6_n [4];
    logic                  neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N_STG-2:0], i_valid};
        end
    end

    // operand pairs: det = EA.P, nu = S.P, nv = D.Q, nt = EB.Q
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            opa[0][k] = 33'(i_ea[k]);   opb[0][k] = 66'(r3_p[k]);
            opa[1][k] = r3_s[k];        opb[1][k] = 66'(r3_p[k]);
            opa[2][k] = 33'(r3_dir[k]); opb[2][k] = r3_q[k];
            opa[3][k] = 33'(i_eb[k]);   opb[3][k] = r3_q[k];
        end
        for (int d = 0; d < 4; d++) begin
            for (int k = 0; k < 3; k++) begin
                n_lo[d][k] = opa[d][k] * $signed({1'b0, opb[d][k][31:0]});
                n_hi[d][k] = opa[d][k] * $signed(opb[d][k][65:32]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_s[k]   <= 33'(i_org[k]) - 33'(i_va[k]);
                r1_dir[k] <= i_dir[k];
                r2_s[k]   <= r1_s[k];
                r2_dir[k] <= r1_dir[k];
                r3_s[k]   <= r2_s[k];
                r3_dir[k] <= r2_dir[k];
                r3_p[k]   <= 65'(r2_pp[2*k]) - 65'(r2_pp[2*k+1]);
                r3_q[k]   <= 66'(r2_qp[2*k]) - 66'(r2_qp[2*k+1]);
            end
            r2_pp[0] <= r1_dir[1] * i_eb[2];
            r2_pp[1] <= r1_dir[2] * i_eb[1];
            r2_pp[2] <= r1_dir[2] * i_eb[0];
            r2_pp[3] <= r1_dir[0] * i_eb[2];
            r2_pp[4] <= r1_dir[0] * i_eb[1];
            r2_pp[5] <= r1_dir[1] * i_eb[0];
            r2_qp[0] <= r1_s[1] * i_ea[2];
            r2_qp[1] <= r1_s[2] * i_ea[1];
            r2_qp[2] <= r1_s[2] * i_ea[0];
            r2_qp[3] <= r1_s[0] * i_ea[2];
            r2_qp[4] <= r1_s[0] * i_ea[1];
            r2_qp[5] <= r1_s[1] * i_ea[0];
            r4_lo <= n_lo;
            r4_hi <= n_hi;
            for (int d = 0; d < 4; d++) begin
                r5_lo[d] <= 70'(r4_lo[d][0]) + 70'(r4_lo[d][1]) + 70'(r4_lo[d][2]);
                r5_hi[d] <= 70'(r4_hi[d][0]) + 70'(r4_hi[d][1]) + 70'(r4_hi[d][2]);
                r6_n[d]  <= (W_N'(r5_hi[d]) <<< 32) + W_N'(r5_lo[d]);
            end
        end
    end

    // fold det sign into the numerators
    assign neg = r6_n[0][W_N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_det <= neg ? W_DET'(-r6_n[0]) : W_DET'(r6_n[0]);
            o_nu  <= neg ? -r6_n[1] : r6_n[1];
            o_nv  <= neg ? -r6_n[2] : r6_n[2];
            o_nt  <= neg ? -r6_n[3] : r6_n[3];
        end
    end

    assign o_valid = r_v[N_STG-1];

endmodule

// ----- sv/rti_bary.sv -----
// Parallel-ray and barycentric range tests by cross-multiplication.
// Depends on rti_pkg.
module rti_bary #(
    parameter int EPSILON_LSB = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic        [rti_pkg::W_DET-1:0] i_det,
    input  logic signed [rti_pkg::W_N-1:0]   i_nu,
    input  logic signed [rti_pkg::W_N-1:0]   i_nv,
    input  logic signed [rti_pkg::W_N-1:0]   i_nt,
    output rti_pkg::t_ctl                    o_ctl,
    output logic        [rti_pkg::W_DET-1:0] o_det,
    output logic        [rti_pkg::W_MAG-1:0] o_mag
);
    import rti_pkg::*;

    localparam logic [W_EPS-1:0] EPS    = W_EPS'(EPSILON_LSB);
    localparam logic [W_N-1:0]   THRESH = W_N'(EPS) << 32;
    localparam int               W_PP   = 33 + W_EPS;

    logic [2:0] r_v;
    logic [W_PP-1:0]        r1_pp [3];
    logic signed [W_N-1:0]  r1_ul, r1_vl, r1_sl, r2_ul, r2_vl, r2_sl, r3_ul, r3_vl, r3_sl;
    logic                   r1_small, r2_small, r3_small;
    logic                   r1_negt, r2_negt, r3_negt;
    logic [W_DET-1:0]       r1_det, r2_det, r3_det;
    logic [W_MAG-1:0]       r1_mag, r2_mag, r3_mag;
    logic [W_N-1:0]         r2_deteps;
    logic signed [W_N-1:0]  r3_lower, r3_upper;
    logic signed [W_N-1:0]  nt_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            o_ctl     <= '0;
        end else if (i_en) begin
            r_v       <= {r_v[1:0], i_valid};
            o_ctl.valid <= r_v[2];
            o_ctl.negt  <= r3_negt;
            o_ctl.ovf   <= 1'b0;
            o_ctl.miss  <= r3_small || (r3_ul < r3_lower) || (r3_upper < r3_ul)
                        || (r3_vl < r3_lower) || (r3_upper < r3_sl);
        end
    end

    assign nt_abs = i_nt[W_N-1] ? -i_nt : i_nt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_pp[j] <= W_PP'(i_det[33*j +: 33]) * W_PP'(EPS);
            end
            r1_ul    <= i_nu <<< 16;
            r1_vl    <= i_nv <<< 16;
            r1_sl    <= (i_nu + i_nv) <<< 16;
            r1_small <= (i_det == '0) || (W_N'(i_det) < THRESH);
            r1_negt  <= i_nt[W_N-1];
            r1_mag   <= W_MAG'(nt_abs) << 16;
            r1_det   <= i_det;

            r2_deteps <= W_N'(r1_pp[0]) + (W_N'(r1_pp[1]) << 33) + (W_N'(r1_pp[2]) << 66);
            r2_ul <= r1_ul; r2_vl <= r1_vl; r2_sl <= r1_sl;
            r2_small <= r1_small; r2_negt <= r1_negt;
            r2_det <= r1_det; r2_mag <= r1_mag;

            r3_lower <= -$signed(r2_deteps);
            r3_upper <= $signed((W_N'(r2_det) << 16) + r2_deteps);
            r3_ul <= r2_ul; r3_vl <= r2_vl; r3_sl <= r2_sl;
            r3_small <= r2_small; r3_negt <= r2_negt;
            r3_det <= r2_det; r3_mag <= r2_mag;

            o_det <= r3_det;
            o_mag <= r3_mag;
        end
    end

endmodule

// ----- sv/rti_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on rti_pkg.
module rti_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  rti_pkg::t_ctl                   i_ctl,
    input  logic        [rti_pkg::W_DET-1:0] i_det,
    input  logic        [rti_pkg::W_MAG-1:0] i_mag,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic signed [rti_pkg::W_DIST-1:0] o_distance
);
    import rti_pkg::*;

    t_ctl               r_c   [N_QBITS+1];
    logic [W_DET-1:0]   r_dv  [N_QBITS+1];
    logic [W_MAG-1:0]   r_rem [N_QBITS+1];
    logic [N_QBITS-1:0] r_q   [N_QBITS+1];

    logic [N_QBITS-1:0] q_fin;
    logic [W_DIST-1:0]  q_dist;
    logic               sat;

    // entry: quotient would need more than N_QBITS bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
        end else if (i_en) begin
            r_c[0] <= '{valid: i_ctl.valid,
                        miss:  i_ctl.miss,
                        negt:  i_ctl.negt,
                        ovf:   W_DIV'(i_mag) >= (W_DIV'(i_det) << N_QBITS)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0]  <= i_det;
            r_rem[0] <= i_mag;
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < N_QBITS; j++) begin : g_stage
        localparam int SH = N_QBITS - 1 - j;
        logic [W_DIV-1:0]   trial;
        logic               take;
        logic [N_QBITS-1:0] q_nx;

        always_comb begin
            trial = W_DIV'(r_rem[j]) - (W_DIV'(r_dv[j]) << SH);
            take  = ~trial[W_DIV-1];
            q_nx  = r_q[j];
            q_nx[SH] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[j+1] <= '0;
            end else if (i_en) begin
                r_c[j+1] <= r_c[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j+1]  <= r_dv[j];
                r_rem[j+1] <= take ? trial[W_MAG-1:0] : r_rem[j];
                r_q[j+1]   <= q_nx;
            end
        end
    end

    // saturate to the Q32.16 range, restore the sign, zero on a miss
    always_comb begin
        q_fin = r_q[N_QBITS];
        if (r_c[N_QBITS].negt) begin
            sat    = r_c[N_QBITS].ovf || (q_fin > Q_NEG_MAX);
            q_dist = -(sat ? W_DIST'(Q_NEG_MAX) : W_DIST'(q_fin));
        end else begin
            sat    = r_c[N_QBITS].ovf || (q_fin > Q_POS_MAX);
            q_dist = sat ? DIST_MAX : W_DIST'(q_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_c[N_QBITS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit      <= ~r_c[N_QBITS].miss;
            o_distance <= r_c[N_QBITS].miss ? '0 : $signed(q_dist);
        end
    end

endmodule

// ----- verif/ray_triangle_intersect_test.sv -----
// Self-checking testbench for the ray/triangle intersection pipeline.
// Depends on rti_pkg and the ray_triangle_intersect top level.
module ray_triangle_intersect_test;
    import rti_pkg::*;

    localparam int EPS_LSB     = 7;
    localparam int DRAIN_WAIT  = 70;      // a little over the pipeline depth
    localparam int QUIET_LIMIT = 5000;    // cycles with no transaction at all
    localparam int MAX_PRINTS  = 20;

    typedef struct {
        bit                hit;
        logic [W_DIST-1:0] distance;
    } t_verdict;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [W_COORD-1:0]    i_origin_x, i_origin_y, i_origin_z;
    logic [W_COORD-1:0]    i_dir_x, i_dir_y, i_dir_z;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_hit;
    logic [W_DIST-1:0]     o_distance;
    logic                  i_cfg_we;
    logic [W_CFG_IDX-1:0]  i_cfg_idx;
    logic [W_CFG_DAT-1:0]  i_cfg_data;

    // triangle registers as the block should hold them
    logic [63:0] tri_reg [0:7];
    t_verdict    pending_verdicts[$];
    int          mismatches;
    int          quiet_cycles;
    int          src_idle;            // percent of items preceded by a gap
    int          snk_idle;            // percent of cycles the result side stalls
    int          hold_left;           // long result-side stall, in cycles

    ray_triangle_intersect #(.EPSILON_LSB(EPS_LSB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_hit(o_hit), .o_distance(o_distance),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Exact Moller-Trumbore in 128-bit signed arithmetic. Every intermediate
    // stays well below 2^120, so nothing wraps. Tests use cross-multiplication.
    function automatic t_verdict intersect_ray(input logic [31:0] org [3],
                                               input logic [31:0] dir [3]);
        logic signed [127:0] d [3], ea [3], eb [3], s [3], p [3], q [3], va [3];
        logic signed [127:0] det, nu, nv, nt, lower, upper, mag, quo;
        bit                  miss, negt;
        t_verdict            v;
        va[0] = $signed(tri_reg[REG_VERTEX_AXY][63:32]);
        va[1] = $signed(tri_reg[REG_VERTEX_AXY][31:0]);
        va[2] = $signed(tri_reg[REG_VERTEX_AZ][31:0]);
        for (int i = 0; i < 3; i++) begin
            ea[i] = $signed(tri_reg[REG_EDGE_A_X + i][31:0]);
            eb[i] = $signed(tri_reg[REG_EDGE_B_X + i][31:0]);
            d[i]  = $signed(dir[i]);
            s[i]  = $signed(org[i]);
            s[i]  = s[i] - va[i];
        end
        p[0] = d[1] * eb[2] - d[2] * eb[1];
        p[1] = d[2] * eb[0] - d[0] * eb[2];
        p[2] = d[0] * eb[1] - d[1] * eb[0];
        q[0] = s[1] * ea[2] - s[2] * ea[1];
        q[1] = s[2] * ea[0] - s[0] * ea[2];
        q[2] = s[0] * ea[1] - s[1] * ea[0];
        det = ea[0] * p[0] + ea[1] * p[1] + ea[2] * p[2];
        nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
        nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt  = eb[0] * q[0] + eb[1] * q[1] + eb[2] * q[2];
        if (det < 0) begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        // det is Q48.48, so the tolerance is EPS_LSB * 2^32 raw
        miss = (det == 0) || (det < (128'(EPS_LSB) <<< 32));
        if (!miss) begin
            lower = -(det * EPS_LSB);
            upper = det * (65536 + EPS_LSB);
            miss = (nu * 65536 < lower) || (upper < nu * 65536) ||
                   (nv * 65536 < lower) || (upper < (nu + nv) * 65536);
        end
        v.hit      = !miss;
        v.distance = '0;
        if (!miss) begin
            negt = nt < 0;
            mag  = (negt ? -nt : nt) * 65536;
            quo  = mag / det;             // truncates toward zero
            if (!negt)
                v.distance = (quo > 128'sh7FFF_FFFF_FFFF) ? DIST_MAX : quo[47:0];
            else begin
                if (quo > 128'sh8000_0000_0000)
                    quo = 128'sh8000_0000_0000;
                v.distance = -quo[47:0];
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // Result side: random stalls, or one long hold when asked.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else
                i_out_ready = ($urandom_range(99) >= snk_idle);
        end
    end

    // Result check against the oldest expected verdict.
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result transaction with none expected");
            else begin
                exp_v = pending_verdicts.pop_front();
                if (o_hit !== exp_v.hit)
                    report_mismatch($sformatf("hit %b, expected %b", o_hit, exp_v.hit));
                if (o_distance !== exp_v.distance)
                    report_mismatch($sformatf("distance %h, expected %h",
                                              o_distance, exp_v.distance));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d quiet cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One ray transaction. Valid is left high after acceptance so that a
    // back-to-back ray does not drop it; idle gaps and the drain lower it.
    task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        logic [31:0] org [3];
        logic [31:0] dir [3];
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_origin_x = ox; i_origin_y = oy; i_origin_z = oz;
        i_dir_x    = dx; i_dir_y    = dy; i_dir_z    = dz;
        org = '{ox, oy, oz};
        dir = '{dx, dy, dz};
        do @(posedge i_clk); while (!o_in_ready);
        pending_verdicts.push_back(intersect_ray(org, dir));
    endtask

    // Drop valid and wait until every expected verdict has come back.
    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx < 8)
            tri_reg[idx[2:0]] = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Load a triangle; 32-bit registers get junk in the unused upper half.
    task automatic load_triangle(input logic [31:0] ea [3], input logic [31:0] eb [3],
                                 input logic [31:0] va [3]);
        for (int i = 0; i < 3; i++) begin
            write_reg(W_CFG_IDX'(REG_EDGE_A_X + i), {$urandom, ea[i]});
            write_reg(W_CFG_IDX'(REG_EDGE_B_X + i), {$urandom, eb[i]});
        end
        write_reg(W_CFG_IDX'(REG_VERTEX_AXY), {va[0], va[1]});
        write_reg(W_CFG_IDX'(REG_VERTEX_AZ), {$urandom, va[2]});
        // indexes past the last register must not disturb anything
        write_reg(W_CFG_IDX'($urandom_range(15, 8)), {$urandom, $urandom});
    endtask

    function automatic logic [31:0] rand_span(input int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_triangle(input bit wide);
        logic [31:0] ea [3], eb [3], va [3];
        for (int i = 0; i < 3; i++) begin
            ea[i] = wide ? $urandom : rand_span(8 << 16);
            eb[i] = wide ? $urandom : rand_span(8 << 16);
            va[i] = wide ? $urandom : rand_span(16 << 16);
        end
        load_triangle(ea, eb, va);
    endtask

    // Mostly rays aimed at a point near the triangle, the rest pure noise.
    task automatic random_ray;
        longint o [3], t [3], u, w;
        logic [31:0] r [6];
        if ($urandom_range(99) < 30) begin
            for (int i = 0; i < 6; i++)
                r[i] = $urandom;
        end else begin
            u = longint'($urandom_range(65536 + 64)) - 32;
            w = longint'($urandom_range(65536 + 64)) - 32;
            if ($urandom_range(3) == 0)
                w = 65536 - u + longint'($urandom_range(32)) - 16;
            o[0] = $signed(tri_reg[REG_VERTEX_AXY][63:32]);
            o[1] = $signed(tri_reg[REG_VERTEX_AXY][31:0]);
            o[2] = $signed(tri_reg[REG_VERTEX_AZ][31:0]);
            for (int i = 0; i < 3; i++) begin
                t[i] = o[i] + ((u * longint'($signed(tri_reg[REG_EDGE_A_X + i][31:0])) +
                                w * longint'($signed(tri_reg[REG_EDGE_B_X + i][31:0])))
                               >>> 16);
                r[i]     = 32'($signed(rand_span(32 << 16)));
                r[i + 3] = 32'(t[i] - longint'($signed(r[i])));
            end
        end
        send_ray(r[0], r[1], r[2], r[3], r[4], r[5]);
    endtask

    // Registers at reset give a degenerate triangle: always a miss.
    task automatic test_reset_triangle;
        send_ray(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        drain();
    endtask

    // Unit right triangle in the plane z = 5, rays mostly fired along +z.
    task automatic test_unit_triangle;
        logic [31:0] ea [3] = '{32'h0001_0000, 32'h0, 32'h0};
        logic [31:0] eb [3] = '{32'h0, 32'h0001_0000, 32'h0};
        logic [31:0] va [3] = '{32'h0, 32'h0, 32'h0005_0000};
        load_triangle(ea, eb, va);
        send_ray(32'h0000_4000, 32'h0000_4000, 0, 0, 0, 32'h0001_0000); // inside, t=5
        send_ray(0, 0, 0, 0, 0, 32'h0001_0000);                         // vertex A
        send_ray(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000);             // u = 1
        send_ray(0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000);             // v = 1
        send_ray(32'h0000_8000, 32'h0000_8000, 0, 0, 0, 32'h0001_0000); // u+v = 1
        send_ray(-32'sd7, 32'h0000_4000, 0, 0, 0, 32'h0001_0000);       // u = -eps: hit
        send_ray(-32'sd8, 32'h0000_4000, 0, 0, 0, 32'h0001_0000);       // beyond eps
        send_ray(32'h0001_0007, 0, 0, 0, 0, 32'h0001_0000);             // u = 1 + eps
        send_ray(32'h0001_0008, 0, 0, 0, 0, 32'h0001_0000);             // past 1 + eps
        send_ray(32'h0000_4000, -32'sd8, 0, 0, 0, 32'h0001_0000);       // v below -eps
        send_ray(32'h0000_8004, 32'h0000_8004, 0, 0, 0, 32'h0001_0000); // sum past 1+eps
        send_ray(32'h0000_9999, 32'h0000_9999, 0, 0, 0, 32'h0001_0000); // clear miss
        send_ray(0, 0, 0, 32'h0001_0000, 0, 0);                         // parallel
        send_ray(32'h0000_4000, 32'h0000_4000, 0, 0, 0, 32'sd6);        // |det| < eps
        send_ray(32'h0000_4000, 32'h0000_4000, 0, 0, 0, 32'sd7);        // det right at eps
        send_ray(32'h0000_4000, 32'h0000_4000, 32'h000A_0000, 0, 0,
                 32'h0001_0000);                                       // behind: t = -5
        send_ray(32'h0000_4000, 32'h0000_4000, 32'h000A_0000, 0, 0, 32'sd7); // far behind
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
        drain();
    endtask

    // Extreme edge and vertex values, the widest det the datapath sees.
    task automatic test_extreme_triangle;
        logic [31:0] ea [3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        logic [31:0] eb [3] = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        logic [31:0] va [3] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        load_triangle(ea, eb, va);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        repeat (4) random_ray();
        drain();
    endtask

    // Random rays under one idle profile; fresh triangle every 50 rays.
    task automatic test_random_rays(input int n_rays, input int s_idle, input int r_idle);
        src_idle = s_idle;
        snk_idle = r_idle;
        for (int k = 0; k < n_rays; k++) begin
            if (k % 50 == 0) begin
                drain();
                random_triangle(k % 150 == 100);
            end
            random_ray();
        end
        drain();
    endtask

    // Result side holds off long enough for the pipeline to fill and
    // push back on the ray input, while rays keep coming.
    task automatic test_backpressure;
        src_idle = 0;
        snk_idle = 0;
        random_triangle(1'b0);
        hold_left = 300;
        repeat (100) random_ray();
        drain();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x    = '0; i_dir_y    = '0; i_dir_z    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        src_idle     = 0;
        snk_idle     = 0;
        hold_left    = 0;
        for (int i = 0; i < 8; i++)
            tri_reg[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle = 17;
        snk_idle = 70;
        test_reset_triangle();
        test_unit_triangle();
        test_extreme_triangle();
        test_random_rays(275, 17, 70);
        test_random_rays(275, 70, 17);
        test_random_rays(275, 0, 0);
        test_backpressure();

        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
